@@ sv/adsr_pkg.sv @@
// Shared types, codes and constants of the Art-Net DMX and sync receiver.
package adsr_pkg;

  typedef enum logic [1:0] {
    REQ_BYTE  = 2'd0,
    REQ_TICK  = 2'd1,
    REQ_LATCH = 2'd2,
    REQ_READ  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    CFG_NET     = 2'd0,
    CFG_SUBNET  = 2'd1,
    CFG_FIRST   = 2'd2,
    CFG_TIMEOUT = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_COPY,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [15:0] packet_length;
    logic [3:0]  read_universe;
    logic [8:0]  read_channel;
  } in_item_t;

  typedef struct packed {
    logic       frame_waiting;
    logic       frame_event;
    logic       sync_active;
    logic [3:0] received_mask;
    logic [7:0] read_data;
    logic       read_valid;
  } out_item_t;

  typedef struct packed {
    logic accept;   // input transfer this cycle
    logic clr;      // clear both stores at the sweep address
    logic copy;     // copy shadow to active at the sweep address
    logic rd_load;  // load the output register from the active store
  } cmd_t;

  typedef struct packed {
    req_e req;
    logic cnt_last;
  } sts_t;

  localparam logic [15:0] OpDmx       = 16'h5000;
  localparam logic [15:0] OpSync      = 16'h5200;
  localparam logic [16:0] HdrMin      = 17'd10;
  localparam logic [16:0] DmxHdr      = 17'd18;
  localparam logic [15:0] DmxMax      = 16'd512;
  localparam logic [15:0] TimeoutRst  = 16'd4000;

  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0: b = 8'h41;
      3'd1: b = 8'h72;
      3'd2: b = 8'h74;
      3'd3: b = 8'h2D;
      3'd4: b = 8'h4E;
      3'd5: b = 8'h65;
      3'd6: b = 8'h74;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

@@ sv/adsr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module adsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/adsr_ctrl.sv @@
// Controller: handshakes, store clearing after reset, latch copy sweep and read sequencing.
module adsr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  adsr_pkg::sts_t sts_i,
  output adsr_pkg::cmd_t cmd_o
);

  adsr_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= adsr_pkg::ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      adsr_pkg::ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.cnt_last) begin
          state_d = adsr_pkg::ST_IDLE;
        end
      end
      adsr_pkg::ST_IDLE: begin
        in_ready_o = free;
        if (in_valid_i && free) begin
          cmd_o.accept = 1'b1;
          unique case (sts_i.req)
            adsr_pkg::REQ_READ: state_d = adsr_pkg::ST_READ;
            adsr_pkg::REQ_LATCH: begin
              state_d     = adsr_pkg::ST_COPY;
              out_valid_d = 1'b1;
            end
            default: out_valid_d = 1'b1;
          endcase
        end
      end
      adsr_pkg::ST_READ: begin
        // The output register was emptied by the transfer that took this read.
        cmd_o.rd_load = 1'b1;
        out_valid_d   = 1'b1;
        state_d       = adsr_pkg::ST_IDLE;
      end
      adsr_pkg::ST_COPY: begin
        cmd_o.copy = 1'b1;
        if (sts_i.cnt_last) begin
          state_d = adsr_pkg::ST_DRAIN;
        end
      end
      adsr_pkg::ST_DRAIN: state_d = adsr_pkg::ST_IDLE;
      default: state_d = adsr_pkg::ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ sv/adsr_dp.sv @@
// Datapath: configuration, packet parser, flags, shadow and active stores, output register.
module adsr_dp #(
  parameter int UNIVERSES = 4,
  parameter int SLOTS     = 512
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i,
  input  adsr_pkg::in_item_t in_item_i,
  output adsr_pkg::out_item_t out_item_o,
  input  adsr_pkg::cmd_t     cmd_i,
  output adsr_pkg::sts_t     sts_o
);

  localparam int Depth = UNIVERSES * SLOTS;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int UW    = (UNIVERSES > 1) ? $clog2(UNIVERSES) : 1;

  // Configuration
  logic [6:0]  net_q;
  logic [3:0]  subnet_q, first_q;
  logic [15:0] timeout_q;

  // Packet and flag state
  logic [15:0]          pos_q, pos_d;
  logic [7:0]           op_lo_q, op_hi_q, hnet_q, subuni_q, len_hi_q, len_lo_q;
  logic [7:0]           op_lo_d, op_hi_d, hnet_d, subuni_d, len_hi_d, len_lo_d;
  logic                 good_q, good_d;
  logic [UNIVERSES-1:0] mask_q, mask_d;
  logic                 sync_q, sync_d;
  logic [16:0]          ms_q, ms_d;
  logic                 ready_q, ready_d;
  logic                 ev;

  logic [AW-1:0] cnt_q;
  logic          cp_wr_q;
  logic [AW-1:0] cp_addr_q;
  logic          rd_valid_q, rd_hit_q;

  adsr_pkg::out_item_t out_q;

  // Byte decode
  adsr_pkg::req_e req;
  logic [7:0]  b;
  logic [15:0] k, op_n, op_cur, len_n, slot;
  logic [9:0]  dlen, dlen_cur;
  logic [4:0]  diff;
  logic        match, match_cur, good_b, wr_en;
  logic [16:0] plen, count;
  logic [UW-1:0] uidx, uidx_cur;
  logic [UNIVERSES-1:0] onehot, mask_j;
  logic        sync_j;
  logic [AW-1:0] sh_waddr, ac_raddr, ac_waddr, sh_wa, sh_raddr;
  logic [7:0]  sh_wdata, ac_wdata, sh_rdata, ac_rdata;
  logic        sh_we, ac_we;
  logic        rd_valid, rd_hit;
  logic [15:0] mask_ext;

  assign req  = adsr_pkg::req_e'(in_item_i.req_type);
  assign b    = in_item_i.data_byte;
  assign k    = pos_q;
  assign plen = {1'b0, in_item_i.packet_length};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      net_q     <= '0;
      subnet_q  <= '0;
      first_q   <= '0;
      timeout_q <= adsr_pkg::TimeoutRst;
    end else if (cfg_we_i) begin
      unique case (adsr_pkg::cfg_idx_e'(cfg_idx_i))
        adsr_pkg::CFG_NET:     net_q     <= cfg_wdata_i[6:0];
        adsr_pkg::CFG_SUBNET:  subnet_q  <= cfg_wdata_i[3:0];
        adsr_pkg::CFG_FIRST:   first_q   <= cfg_wdata_i[3:0];
        adsr_pkg::CFG_TIMEOUT: timeout_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  function automatic logic [9:0] clamp_len(input logic [15:0] n);
    return (n > adsr_pkg::DmxMax) ? 10'd512 : n[9:0];
  endfunction

  function automatic logic [3:0] mask_ext_f(input logic [UNIVERSES-1:0] m);
    logic [15:0] e;
    e = 16'(m);
    return e[3:0];
  endfunction

  // Header fields as they stand after this byte.
  always_comb begin
    op_lo_d  = (k == 16'd8)  ? b : op_lo_q;
    op_hi_d  = (k == 16'd9)  ? b : op_hi_q;
    hnet_d   = (k == 16'd14) ? b : hnet_q;
    subuni_d = (k == 16'd15) ? b : subuni_q;
    len_hi_d = (k == 16'd16) ? b : len_hi_q;
    len_lo_d = (k == 16'd17) ? b : len_lo_q;
    op_n     = {op_hi_d, op_lo_d};
    op_cur   = {op_hi_q, op_lo_q};
    len_n    = {len_hi_d, len_lo_d};
    dlen     = clamp_len(len_n);
    dlen_cur = clamp_len({len_hi_q, len_lo_q});
    diff     = {1'b0, subuni_d[3:0]} - {1'b0, first_q};
    match    = (hnet_d[6:0] == net_q) && (subuni_d[7:4] == subnet_q)
               && (subuni_d[3:0] >= first_q) && (diff < 5'(UNIVERSES));
    uidx     = diff[UW-1:0];
    // Bytes past the header never change the address fields.
    match_cur = match;
    uidx_cur  = uidx;
  end

  always_comb begin
    good_b = good_q;
    if (k < 16'd8 && b != adsr_pkg::sig_byte(k[2:0])) begin
      good_b = 1'b0;
    end
    if (k == 16'd17 && op_n == adsr_pkg::OpDmx
        && (!match || plen < adsr_pkg::DmxHdr + 17'(dlen))) begin
      good_b = 1'b0;
    end
    slot  = k - 16'd18;
    wr_en = (k >= 16'd18) && good_q && (op_cur == adsr_pkg::OpDmx)
            && (slot < 16'(dlen_cur)) && (slot < 16'(SLOTS)) && match_cur;
    sh_wa = AW'(32'(uidx_cur) * SLOTS + 32'(slot));
  end

  // Flag and packet state updates for one accepted item.
  always_comb begin
    pos_d   = pos_q;
    good_d  = good_q;
    mask_d  = mask_q;
    sync_d  = sync_q;
    ms_d    = ms_q;
    ready_d = ready_q;
    ev      = 1'b0;
    count   = {1'b0, k} + 17'd1;
    onehot  = UNIVERSES'(1) << uidx;
    mask_j  = mask_q | onehot;
    sync_j  = sync_q && !(ms_q > {1'b0, timeout_q});
    unique case (req)
      adsr_pkg::REQ_BYTE: begin
        if (!in_item_i.last_byte) begin
          pos_d  = (pos_q != 16'hFFFF) ? pos_q + 16'd1 : pos_q;
          good_d = good_b;
        end else begin
          pos_d  = '0;
          good_d = 1'b1;
          if (good_b && count >= adsr_pkg::HdrMin && plen >= adsr_pkg::HdrMin) begin
            if (op_n == adsr_pkg::OpDmx) begin
              if (plen >= adsr_pkg::DmxHdr && count >= adsr_pkg::DmxHdr + 17'(dlen)
                  && match) begin
                mask_d = mask_j;
                sync_d = sync_j;
                if (!sync_j && mask_j == '1) begin
                  ready_d = 1'b1;
                  ev      = 1'b1;
                end
              end
            end else if (op_n == adsr_pkg::OpSync) begin
              sync_d  = 1'b1;
              ms_d    = '0;
              ready_d = 1'b1;
              ev      = 1'b1;
            end
          end
        end
      end
      adsr_pkg::REQ_TICK: ms_d = (ms_q != '1) ? ms_q + 17'd1 : ms_q;
      adsr_pkg::REQ_LATCH: begin
        ready_d = 1'b0;
        mask_d  = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      op_lo_q  <= '0;
      op_hi_q  <= '0;
      hnet_q   <= '0;
      subuni_q <= '0;
      len_hi_q <= '0;
      len_lo_q <= '0;
      good_q   <= 1'b1;
      mask_q   <= '0;
      sync_q   <= 1'b0;
      ms_q     <= '0;
      ready_q  <= 1'b0;
      cnt_q    <= '0;
      cp_wr_q  <= 1'b0;
    end else begin
      cp_wr_q <= cmd_i.copy;
      if (cmd_i.clr || cmd_i.copy) begin
        cnt_q <= sts_o.cnt_last ? '0 : cnt_q + AW'(1);
      end
      if (cmd_i.accept) begin
        pos_q   <= pos_d;
        good_q  <= good_d;
        mask_q  <= mask_d;
        sync_q  <= sync_d;
        ms_q    <= ms_d;
        ready_q <= ready_d;
        if (req == adsr_pkg::REQ_BYTE) begin
          if (in_item_i.last_byte) begin
            op_lo_q  <= '0;
            op_hi_q  <= '0;
            hnet_q   <= '0;
            subuni_q <= '0;
            len_hi_q <= '0;
            len_lo_q <= '0;
          end else begin
            op_lo_q  <= op_lo_d;
            op_hi_q  <= op_hi_d;
            hnet_q   <= hnet_d;
            subuni_q <= subuni_d;
            len_hi_q <= len_hi_d;
            len_lo_q <= len_lo_d;
          end
        end
      end
    end
  end

  // Read address decode
  assign rd_valid = 5'(in_item_i.read_universe) < 5'(UNIVERSES);
  assign rd_hit   = rd_valid && (10'(in_item_i.read_channel) < 10'(SLOTS));
  assign ac_raddr = AW'(32'(in_item_i.read_universe) * SLOTS + 32'(in_item_i.read_channel));

  always_ff @(posedge clk_i) begin
    cp_addr_q <= cnt_q;
    if (cmd_i.accept) begin
      rd_valid_q <= rd_valid;
      rd_hit_q   <= rd_hit;
    end
  end

  // Store ports
  always_comb begin
    sh_raddr = cnt_q;
    sh_we    = cmd_i.clr || (cmd_i.accept && req == adsr_pkg::REQ_BYTE && wr_en);
    sh_waddr = cmd_i.clr ? cnt_q : sh_wa;
    sh_wdata = cmd_i.clr ? 8'h00 : b;
    ac_we    = cmd_i.clr || cp_wr_q;
    ac_waddr = cmd_i.clr ? cnt_q : cp_addr_q;
    ac_wdata = cmd_i.clr ? 8'h00 : sh_rdata;
  end

  adsr_ram #(.WIDTH(8), .DEPTH(Depth)) u_shadow (
    .clk_i   (clk_i),
    .we_i    (sh_we),
    .waddr_i (sh_waddr),
    .wdata_i (sh_wdata),
    .raddr_i (sh_raddr),
    .rdata_o (sh_rdata)
  );

  adsr_ram #(.WIDTH(8), .DEPTH(Depth)) u_active (
    .clk_i   (clk_i),
    .we_i    (ac_we),
    .waddr_i (ac_waddr),
    .wdata_i (ac_wdata),
    .raddr_i (ac_raddr),
    .rdata_o (ac_rdata)
  );

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && req != adsr_pkg::REQ_READ) begin
      out_q.frame_waiting <= ready_d;
      out_q.frame_event   <= ev;
      out_q.sync_active   <= sync_d;
      out_q.received_mask <= mask_ext_f(mask_d);
      out_q.read_data     <= '0;
      out_q.read_valid    <= 1'b0;
    end else if (cmd_i.rd_load) begin
      out_q.frame_waiting <= ready_q;
      out_q.frame_event   <= 1'b0;
      out_q.sync_active   <= sync_q;
      out_q.received_mask <= mask_ext[3:0];
      out_q.read_data     <= rd_hit_q ? ac_rdata : 8'h00;
      out_q.read_valid    <= rd_valid_q;
    end
  end

  assign mask_ext     = 16'(mask_q);
  assign out_item_o   = out_q;
  assign sts_o.req    = req;
  assign sts_o.cnt_last = (cnt_q == AW'(Depth - 1));

endmodule

@@ sv/artnet_dmx_sync_receiver.sv @@
// Art-Net ArtDmx / OpSync receiver top level: controller plus datapath.
// Results: byte, tick and latch items set the output register at the transfer; reads pass
// through the registered active store read and then the output register.
// Throughput: one item per cycle for bytes and ticks while the output is taken; a read holds
// off the next item until its data is loaded, and a latch blocks input while the copy sweep
// walks the store one byte a cycle. Reset: flags and counters clear at once; a clearing pass
// then zeroes both stores, with no input accepted until it ends.
module artnet_dmx_sync_receiver #(
  parameter int UNIVERSES = 4,
  parameter int SLOTS     = 512
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  adsr_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output adsr_pkg::out_item_t out_item_o
);

  adsr_pkg::cmd_t cmd;
  adsr_pkg::sts_t sts;

  adsr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  adsr_dp #(.UNIVERSES(UNIVERSES), .SLOTS(SLOTS)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_item_i   (in_item_i),
    .out_item_o  (out_item_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
